### design/assert_macros.svh
// Assertion macros used by the design file.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`endif

### design/crrw_pkg.sv
package crrw_pkg;

   localparam int MAX_ROWS    = 256;
   localparam int MAX_COLUMNS = 8;
   localparam int CELL_DEPTH  = MAX_ROWS * MAX_COLUMNS;

   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLUMNS);
   localparam int NCOL_W   = $clog2(MAX_COLUMNS + 1);
   localparam int CNT_W    = $clog2(MAX_ROWS + 1);
   localparam int CELL_AW  = $clog2(CELL_DEPTH);
   localparam int CELL_W   = 8;
   localparam int MODE_W   = 2;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 9;

   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   localparam logic [CSR_IW-1:0] CSR_CHAINED    = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_MARK_COL   = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_TARGET_COL = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_MARK_VAL   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_ROWS       = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_COLS       = 3'd5;

endpackage

### design/crrw_if.sv
interface crrw_req_if;
   logic                          valid;
   logic                          ready;
   logic [crrw_pkg::MODE_W-1:0]   mode;
   logic [crrw_pkg::ROW_W-1:0]    row;
   logic [crrw_pkg::COL_W-1:0]    column;
   logic [crrw_pkg::CELL_W-1:0]   cell_value;

   modport source (output valid, mode, row, column, cell_value, input ready);
   modport sink (input valid, mode, row, column, cell_value, output ready);
endinterface

interface crrw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          success;
   logic                          row_mapped;
   logic [crrw_pkg::ROW_W-1:0]    mapped_index;
   logic [crrw_pkg::CNT_W-1:0]    mapped_count;

   modport source (output valid, success, row_mapped, mapped_index, mapped_count,
                   input ready);
   modport sink (input valid, success, row_mapped, mapped_index, mapped_count,
                 output ready);
endinterface

### design/chained_row_renumber_walk.sv
// A cell write, a single-mode build or a bad request is answered from the start state,
// a query from the query state after the registered read of the index memory; a chained
// build alternates between mapping a row and reading its marker and target cells.
// Throughput: one request at a time; the next is accepted once the previous has finished.
// Reset (synchronous, active high) restores the register defaults, marks every row
// unmapped and clears the mapped count; the cell and index memories are not cleared.
`include "assert_macros.svh"

module chained_row_renumber_walk (
   input  logic                           clock,
   input  logic                           reset,
   crrw_req_if.sink                       req_if,
   crrw_rsp_if.source                     rsp_if,
   input  logic                           csr_wr_en,
   input  logic [crrw_pkg::CSR_IW-1:0]    csr_index,
   input  logic [crrw_pkg::CSR_DW-1:0]    csr_data
);

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_NEXT  = 3'd3;
   localparam logic [2:0] ST_QUERY = 3'd4;

   localparam int ROW_W   = crrw_pkg::ROW_W;
   localparam int CNT_W   = crrw_pkg::CNT_W;
   localparam int NCOL_W  = crrw_pkg::NCOL_W;
   localparam int COL_W   = crrw_pkg::COL_W;
   localparam int CELL_AW = crrw_pkg::CELL_AW;
   localparam int CELL_W  = crrw_pkg::CELL_W;
   localparam int PROD_W  = ROW_W + NCOL_W;

   // Flat cell address: row times the row stride plus the column. A marker or target
   // column beyond the row simply reaches into the cells of the following rows.
   function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [NCOL_W-1:0] stride,
                                                    input logic [COL_W-1:0] c);
      logic [PROD_W-1:0] sum;
      sum = PROD_W'(r) * PROD_W'(stride) + PROD_W'(c);
      return sum[CELL_AW-1:0];
   endfunction

   // Configuration registers.
   logic                        chained_ff;
   logic [COL_W-1:0]            mark_col_ff;
   logic [COL_W-1:0]            target_col_ff;
   logic [CELL_W-1:0]           mark_val_ff;
   logic [CNT_W-1:0]            rows_cfg_ff;
   logic [NCOL_W-1:0]           cols_cfg_ff;

   // Request registers.
   logic [crrw_pkg::MODE_W-1:0] mode_ff;
   logic [ROW_W-1:0]            row_ff;
   logic [COL_W-1:0]            column_ff;
   logic [CELL_W-1:0]           value_ff;

   // Sequencer and walk state.
   logic [2:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            cur_ff, cur_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [crrw_pkg::MAX_ROWS-1:0] valid_ff;

   // Memories and their registered read data.
   logic [CELL_W-1:0]           cell_mem [crrw_pkg::CELL_DEPTH];
   logic [ROW_W-1:0]            index_mem [crrw_pkg::MAX_ROWS];
   logic [CELL_W-1:0]           mark_data_ff;
   logic [CELL_W-1:0]           target_data_ff;
   logic [ROW_W-1:0]            index_data_ff;

   // Response register.
   logic                        rsp_valid_ff;
   logic                        rsp_success_ff, rsp_success_in;
   logic                        rsp_mapped_ff, rsp_mapped_in;
   logic [ROW_W-1:0]            rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]            rsp_count_ff, rsp_count_in;

   logic                        req_accept;
   logic                        out_free;
   logic                        rsp_load;
   logic                        cell_we;
   logic                        map_we;
   logic [ROW_W-1:0]            map_row;
   logic [CNT_W-1:0]            eff_rows;
   logic [NCOL_W-1:0]           eff_cols;
   logic [ROW_W-1:0]            cur_row;
   logic [CELL_AW-1:0]          mark_addr;
   logic [CELL_AW-1:0]          target_addr;
   logic [CELL_AW-1:0]          write_addr;
   logic                        row_ok;

   // Registers out of range are used saturated to their legal span.
   always_comb begin
      if (rows_cfg_ff == '0) begin
         eff_rows = CNT_W'(1);
      end else if (rows_cfg_ff > CNT_W'(crrw_pkg::MAX_ROWS)) begin
         eff_rows = CNT_W'(crrw_pkg::MAX_ROWS);
      end else begin
         eff_rows = rows_cfg_ff;
      end
      if (cols_cfg_ff == '0) begin
         eff_cols = NCOL_W'(1);
      end else if (cols_cfg_ff > NCOL_W'(crrw_pkg::MAX_COLUMNS)) begin
         eff_cols = NCOL_W'(crrw_pkg::MAX_COLUMNS);
      end else begin
         eff_cols = cols_cfg_ff;
      end
   end

   assign cur_row     = cur_ff[ROW_W-1:0];
   assign mark_addr   = cell_addr(cur_row, eff_cols, mark_col_ff);
   assign target_addr = cell_addr(cur_row, eff_cols, target_col_ff);
   assign write_addr  = cell_addr(row_ff, eff_cols, column_ff);
   assign row_ok      = {1'b0, row_ff} < eff_rows;

   // One request is held at a time; the response register lets a finished result wait
   // for the consumer while the next request is taken in.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // Sequencer. Every state that produces a result holds until the response register
   // is free, and makes no change to the map before it can finish.
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      count_in       = count_ff;
      cell_we        = 1'b0;
      map_we         = 1'b0;
      map_row        = cur_row;
      rsp_load       = 1'b0;
      rsp_success_in = 1'b0;
      rsp_mapped_in  = 1'b0;
      rsp_index_in   = '0;
      rsp_count_in   = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            case (mode_ff)
               crrw_pkg::MODE_WRITE: begin
                  if (out_free) begin
                     // A write outside the rows or columns in use is dropped.
                     cell_we        = row_ok && ({1'b0, column_ff} < eff_cols);
                     rsp_load       = 1'b1;
                     rsp_success_in = cell_we;
                     state_in       = ST_IDLE;
                  end
               end
               crrw_pkg::MODE_BUILD: begin
                  if (row_ok && chained_ff) begin
                     cur_in   = {1'b0, row_ff};
                     state_in = ST_CHECK;
                  end else if (out_free) begin
                     // Single mode maps the start row alone, if it is not mapped yet.
                     if (row_ok && !valid_ff[row_ff]) begin
                        map_we   = 1'b1;
                        map_row  = row_ff;
                        count_in = count_ff + CNT_W'(1);
                     end
                     rsp_load       = 1'b1;
                     rsp_success_in = row_ok;
                     rsp_count_in   = count_in;
                     state_in       = ST_IDLE;
                  end
               end
               crrw_pkg::MODE_QUERY: begin
                  // The index memory is read at the request row this cycle.
                  state_in = ST_QUERY;
               end
               default: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_CHECK: begin
            if (cur_ff >= eff_rows) begin
               // The walk has left the rows in use: failure, earlier maps stay.
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (valid_ff[cur_row]) begin
               // Reaching a row that is already mapped ends the walk with success.
               if (out_free) begin
                  rsp_load       = 1'b1;
                  rsp_success_in = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               // Map this row; its marker and target cells are read at the same time.
               map_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (mark_data_ff == mark_val_ff) begin
               cur_in = {1'b0, target_data_ff};
            end else begin
               cur_in = cur_ff + CNT_W'(1);
            end
            state_in = ST_CHECK;
         end
         ST_QUERY: begin
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_success_in = row_ok;
               rsp_mapped_in  = row_ok && valid_ff[row_ff];
               rsp_index_in   = rsp_mapped_in ? index_data_ff : '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (map_we) begin
            valid_ff[map_row] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration registers; the user must write them only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         chained_ff    <= 1'b1;
         mark_col_ff   <= COL_W'(0);
         target_col_ff <= COL_W'(1);
         mark_val_ff   <= CELL_W'(255);
         rows_cfg_ff   <= CNT_W'(crrw_pkg::MAX_ROWS);
         cols_cfg_ff   <= NCOL_W'(2);
      end else if (csr_wr_en) begin
         case (csr_index)
            crrw_pkg::CSR_CHAINED:    chained_ff    <= csr_data[0];
            crrw_pkg::CSR_MARK_COL:   mark_col_ff   <= csr_data[COL_W-1:0];
            crrw_pkg::CSR_TARGET_COL: target_col_ff <= csr_data[COL_W-1:0];
            crrw_pkg::CSR_MARK_VAL:   mark_val_ff   <= csr_data[CELL_W-1:0];
            crrw_pkg::CSR_ROWS:       rows_cfg_ff   <= csr_data[CNT_W-1:0];
            crrw_pkg::CSR_COLS:       cols_cfg_ff   <= csr_data[NCOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (req_accept) begin
         mode_ff   <= req_if.mode;
         row_ff    <= req_if.row;
         column_ff <= req_if.column;
         value_ff  <= req_if.cell_value;
      end
      if (rsp_load) begin
         rsp_success_ff <= rsp_success_in;
         rsp_mapped_ff  <= rsp_mapped_in;
         rsp_index_ff   <= rsp_index_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   // Cell memory: one write port, two registered read ports at the current walk row.
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[write_addr] <= value_ff;
      end
      mark_data_ff   <= cell_mem[mark_addr];
      target_data_ff <= cell_mem[target_addr];
   end

   // Index memory: written with the running count as a row is mapped, read for queries.
   always_ff @(posedge clock) begin
      if (map_we) begin
         index_mem[map_row] <= count_ff[ROW_W-1:0];
      end
      index_data_ff <= index_mem[row_ff];
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.success      = rsp_success_ff;
   assign rsp_if.row_mapped   = rsp_mapped_ff;
   assign rsp_if.mapped_index = rsp_index_ff;
   assign rsp_if.mapped_count = rsp_count_ff;

   // A row is never mapped twice.
   `ASSERT_IMPLIES(a_map_fresh, clock, reset, map_we, !valid_ff[map_row])
   // The mapped count moves by at most one per cycle, and only with a map write.
   `ASSERT_ALWAYS(a_count_step, clock, reset, (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1)))
   // A result never overwrites one that the consumer has not yet taken.
   `ASSERT_IMPLIES(a_rsp_no_overrun, clock, reset, rsp_load, out_free)
   // In the check state the walk never holds a row more than one past the table's last row.
   `ASSERT_IMPLIES(a_walk_bounded, clock, reset, state_ff == ST_CHECK, cur_ff <= CNT_W'(crrw_pkg::MAX_ROWS))

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

import crrw_pkg::*;

typedef struct packed {
   logic [MODE_W-1:0] mode;
   logic [ROW_W-1:0]  row;
   logic [COL_W-1:0]  column;
   logic [CELL_W-1:0] cell_value;
} renumber_req_type;

typedef struct packed {
   logic              success;
   logic              row_mapped;
   logic [ROW_W-1:0]  mapped_index;
   logic [CNT_W-1:0]  mapped_count;
} renumber_rsp_type;

// Keeps its own copy of the table, the renumbering map and the registers, and
// turns every accepted request into the response it must produce.
class renumber_scoreboard;
   bit                chained;
   bit [COL_W-1:0]    marker_col;
   bit [COL_W-1:0]    target_col;
   bit [CELL_W-1:0]   marker_val;
   bit [CNT_W-1:0]    rows_reg;
   bit [NCOL_W-1:0]   cols_reg;
   bit [CELL_W-1:0]   cells [CELL_DEPTH];
   bit                written [CELL_DEPTH];
   bit [MAX_ROWS-1:0] map_valid;
   bit [ROW_W-1:0]    map_index [MAX_ROWS];
   bit [CNT_W-1:0]    mapped_total;
   renumber_rsp_type  pending_results [$];
   int                mismatches;

   function new();
      chained      = 1'b1;
      marker_col   = 0;
      target_col   = 1;
      marker_val   = 8'hFF;
      rows_reg     = MAX_ROWS;
      cols_reg     = 2;
      map_valid    = '0;
      mapped_total = '0;
      mismatches   = 0;
      foreach (cells[i]) begin
         cells[i]   = '0;
         written[i] = 1'b0;
      end
   endfunction

   function int eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
   endfunction

   function int eff_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
      return cols_reg;
   endfunction

   function int cell_addr(int row, int col);
      return (row * eff_cols() + col) % CELL_DEPTH;
   endfunction

   function void set_register(logic [CSR_IW-1:0] index, logic [CSR_DW-1:0] data);
      case (index)
         CSR_CHAINED:    chained    = data[0];
         CSR_MARK_COL:   marker_col = data[COL_W-1:0];
         CSR_TARGET_COL: target_col = data[COL_W-1:0];
         CSR_MARK_VAL:   marker_val = data[CELL_W-1:0];
         CSR_ROWS:       rows_reg   = data[CNT_W-1:0];
         CSR_COLS:       cols_reg   = data[NCOL_W-1:0];
         default: ;
      endcase
   endfunction

   // Walks from a start row. With commit clear nothing changes and the walk stops
   // at the first cell it would read that was never written (gap, else -1).
   function bit walk_from(int start, bit commit, output int gap, output bit gap_on_target);
      bit [MAX_ROWS-1:0] seen;
      bit [CNT_W-1:0]    count;
      bit                ok;
      bit                done;
      int                limit;
      int                cur;
      int                guard;
      int                a;
      seen          = map_valid;
      count         = mapped_total;
      limit         = eff_rows();
      cur           = start;
      ok            = 1'b0;
      done          = 1'b0;
      gap           = -1;
      gap_on_target = 1'b0;
      if (start < limit && !chained) begin
         if (!seen[start]) begin
            if (commit) map_index[start] = count[ROW_W-1:0];
            seen[start] = 1'b1;
            count++;
         end
         ok = 1'b1;
      end else if (start < limit) begin
         for (guard = 0; guard <= MAX_ROWS && cur < limit && !done; guard++) begin
            if (seen[cur]) begin
               ok   = 1'b1;
               done = 1'b1;
            end else begin
               if (commit) map_index[cur] = count[ROW_W-1:0];
               seen[cur] = 1'b1;
               count++;
               a = cell_addr(cur, marker_col);
               if (!written[a] && !commit) begin
                  gap  = a;
                  done = 1'b1;
               end else if (cells[a] == marker_val) begin
                  a = cell_addr(cur, target_col);
                  if (!written[a] && !commit) begin
                     gap           = a;
                     gap_on_target = 1'b1;
                     done          = 1'b1;
                  end else begin
                     cur = cells[a];
                  end
               end else begin
                  cur = cur + 1;
               end
            end
         end
      end
      if (commit) begin
         map_valid    = seen;
         mapped_total = count;
      end
      return ok;
   endfunction

   function void note_request(renumber_req_type r);
      renumber_rsp_type e;
      int               gap;
      bit               on_target;
      e = '0;
      case (r.mode)
         MODE_WRITE: begin
            if (r.row < eff_rows() && r.column < eff_cols()) begin
               cells[cell_addr(r.row, r.column)]   = r.cell_value;
               written[cell_addr(r.row, r.column)] = 1'b1;
               e.success = 1'b1;
            end
         end
         MODE_BUILD: e.success = walk_from(r.row, 1'b1, gap, on_target);
         MODE_QUERY: begin
            if (r.row < eff_rows()) begin
               e.success = 1'b1;
               if (map_valid[r.row]) begin
                  e.row_mapped   = 1'b1;
                  e.mapped_index = map_index[r.row];
               end
            end
         end
         default: ;
      endcase
      e.mapped_count  = mapped_total;
      pending_results = {pending_results, e};
   endfunction

   function void report(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
   endfunction

   function void check_result(renumber_rsp_type got);
      renumber_rsp_type want;
      if (pending_results.size() == 0) begin
         mismatches++;
         $display("%0t: response with no request outstanding", $time);
         return;
      end
      want = pending_results.pop_front();
      if (got.success !== want.success)
         report("success", CNT_W'(want.success), CNT_W'(got.success));
      if (got.row_mapped !== want.row_mapped)
         report("row_mapped", CNT_W'(want.row_mapped), CNT_W'(got.row_mapped));
      if (got.mapped_index !== want.mapped_index)
         report("mapped_index", CNT_W'(want.mapped_index), CNT_W'(got.mapped_index));
      if (got.mapped_count !== want.mapped_count)
         report("mapped_count", want.mapped_count, got.mapped_count);
   endfunction
endclass

module tb;

   // The fourth request code has no meaning; the block must answer it and change nothing.
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int PHASES         = 12;
   localparam int PHASE_REQUESTS = 117;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_data;
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;

   crrw_req_if req_bus ();
   crrw_rsp_if rsp_bus ();

   renumber_scoreboard sb;

   chained_row_renumber_walk dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The response side stalls at random, at a rate that each phase of the run sets.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Responses are taken at the rising edge, where the values seen are the ones
   // that stood before the block updated anything in that step.
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_result({rsp_bus.success, rsp_bus.row_mapped, rsp_bus.mapped_index,
                          rsp_bus.mapped_count});
   end

   // Presents one request, idling first at the phase's rate, and hands it to the
   // scoreboard at the edge where the block takes it. Since the prediction is made
   // at acceptance, the scoreboard always holds the state the block will work on.
   task automatic send_request(input logic [MODE_W-1:0] mode, input int row,
                               input int column, input int value);
      renumber_req_type r;
      r.mode       = mode;
      r.row        = ROW_W'(row);
      r.column     = COL_W'(column);
      r.cell_value = CELL_W'(value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= r.mode;
      req_bus.row        <= r.row;
      req_bus.column     <= r.column;
      req_bus.cell_value <= r.cell_value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(r);
   endtask

   task automatic write_register(input logic [CSR_IW-1:0] index, input int data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_data  <= CSR_DW'(data);
      @(posedge clock);
      sb.set_register(index, CSR_DW'(data));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Stops sending and waits until every outstanding request has been answered.
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // A walk must never read a cell that was never written. Before a build goes out,
   // the walk is tried on the scoreboard's copy; every unwritten cell it would touch
   // is written first, with a value chosen for its role so that jumps happen and
   // often land inside the rows in use. Where such a cell lies beyond the rows in
   // use it cannot be written, and a query of the start row is sent instead.
   task automatic issue_build(input int start);
      int gap;
      int stride;
      int value;
      bit on_target;
      forever begin
         void'(sb.walk_from(start, 1'b0, gap, on_target));
         if (gap < 0) begin
            send_request(MODE_BUILD, start, $urandom_range(7), $urandom_range(255));
            return;
         end
         stride = sb.eff_cols();
         if (gap / stride >= sb.eff_rows()) begin
            send_request(MODE_QUERY, start, $urandom_range(7), $urandom_range(255));
            return;
         end
         if (on_target)
            value = ($urandom_range(9) < 7) ? $urandom_range(sb.eff_rows() - 1)
                                            : $urandom_range(255);
         else
            value = ($urandom_range(3) == 0) ? sb.marker_val : $urandom_range(255);
         send_request(MODE_WRITE, gap / stride, gap % stride, value);
      end
   endtask

   // Register settings per phase. The first phases and the last two take the
   // extremes, including values beyond the legal range that must saturate; the
   // middle ones widen the rows in use step by step so that fresh, unmapped rows
   // keep turning up although the map is never cleared.
   task automatic configure_phase(input int p);
      int rows;
      int cols;
      int mark;
      case (p)
         0:       rows = 0;
         1:       rows = 1;
         10:      rows = 511;
         11:      rows = MAX_ROWS;
         default: rows = 8 + p * 24 + $urandom_range(15);
      endcase
      case (p % 5)
         0:       cols = 0;
         1:       cols = 15;
         2:       cols = MAX_COLUMNS;
         3:       cols = 1;
         default: cols = $urandom_range(7, 2);
      endcase
      case ($urandom_range(3))
         0:       mark = 0;
         1:       mark = 255;
         default: mark = $urandom_range(255);
      endcase
      write_register(CSR_CHAINED, (p == 1) ? 0 : ($urandom_range(3) != 0));
      write_register(CSR_MARK_COL, (p == 2) ? 7 : $urandom_range(7));
      write_register(CSR_TARGET_COL, (p == 3) ? 0 : $urandom_range(7));
      write_register(CSR_MARK_VAL, mark);
      write_register(CSR_ROWS, rows);
      write_register(CSR_COLS, cols);
   endtask

   // One random request. Most are well-formed: builds from rows in use, queries
   // and cell writes inside the table. The rest go beyond the rows or columns in
   // use, or carry the unused request code, which does not count towards the phase.
   task automatic random_request(output bit counted);
      int roll;
      int rows;
      int value;
      int column;
      roll    = $urandom_range(99);
      rows    = sb.eff_rows();
      counted = 1'b1;
      if (roll < 40) begin
         issue_build((roll < 36) ? $urandom_range(rows - 1) : $urandom_range(255));
      end else if (roll < 60) begin
         send_request(MODE_QUERY, (roll < 56) ? $urandom_range(rows - 1) : $urandom_range(255),
                      $urandom_range(7), $urandom_range(255));
      end else if (roll < 94) begin
         case ($urandom_range(3))
            0:       value = sb.marker_val;
            1:       value = $urandom_range(rows - 1);
            default: value = $urandom_range(255);
         endcase
         column = ($urandom_range(99) < 85) ? $urandom_range(sb.eff_cols() - 1)
                                            : $urandom_range(7);
         send_request(MODE_WRITE, (roll < 90) ? $urandom_range(rows - 1) : $urandom_range(255),
                      column, value);
      end else begin
         send_request(MODE_SPARE, $urandom_range(255), $urandom_range(7), $urandom_range(255));
         counted = 1'b0;
      end
   endtask

   initial begin
      int  p;
      int  done_in_phase;
      bit  counted;
      bit  paused;
      sb                 = new();
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      req_bus.valid      = 1'b0;
      req_bus.mode       = '0;
      req_bus.row        = '0;
      req_bus.column     = '0;
      req_bus.cell_value = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: two columns, all rows in use,
      // chained walks, jumps on 255 in column 0 to the row held in column 1.
      // Empty map, the unused code, and writes beyond the columns in use first.
      send_request(MODE_QUERY, 0, 0, 0);
      send_request(MODE_QUERY, 255, 7, 255);
      send_request(MODE_SPARE, 255, 7, 255);
      send_request(MODE_WRITE, 0, 2, 8'h11);
      send_request(MODE_WRITE, 0, 7, 255);
      // A small chain: row 0 falls through to row 1, which jumps to row 3; row 3
      // falls through to row 4, which jumps back to row 0 and so ends the walk on
      // a row that is already mapped.
      send_request(MODE_WRITE, 0, 0, 0);
      send_request(MODE_WRITE, 0, 1, 8'hAA);
      send_request(MODE_WRITE, 1, 0, 255);
      send_request(MODE_WRITE, 1, 1, 3);
      send_request(MODE_WRITE, 3, 0, 8'h7F);
      send_request(MODE_WRITE, 4, 0, 255);
      send_request(MODE_WRITE, 4, 1, 0);
      send_request(MODE_WRITE, 255, 1, 8'h55);
      issue_build(0);
      send_request(MODE_QUERY, 3, 0, 0);
      send_request(MODE_QUERY, 2, 0, 0);
      // Eight rows in use: a walk that runs off the last row fails but keeps the
      // row it mapped; writes, builds and queries beyond the rows in use are refused.
      settle();
      write_register(CSR_ROWS, 8);
      send_request(MODE_WRITE, 7, 0, 8'h11);
      issue_build(7);
      send_request(MODE_WRITE, 8, 0, 8'h22);
      issue_build(9);
      send_request(MODE_QUERY, 100, 0, 0);
      // Single mode maps the start row only, and a second build of it adds nothing.
      settle();
      write_register(CSR_CHAINED, 0);
      issue_build(6);
      issue_build(6);
      send_request(MODE_QUERY, 6, 0, 0);
      send_request(MODE_QUERY, 7, 0, 0);

      // Random part. The idling pattern rotates with the phase: none, the sender
      // idle most of the time, the receiver stalling most of the time, then both.
      for (p = 0; p < PHASES; p++) begin
         settle();
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         configure_phase(p);
         done_in_phase = 0;
         paused        = 1'b0;
         while (done_in_phase < PHASE_REQUESTS) begin
            // Halfway through, the sender holds back until the block has drained.
            if (!paused && done_in_phase >= PHASE_REQUESTS / 2) begin
               settle();
               paused = 1'b1;
            end
            random_request(counted);
            done_in_phase += counted;
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Far beyond the slowest correct run, even with the longest walks and stalls.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
